// ===== sv/drfl_pkg.sv =====
// Shared types, constants and codes for the dated rate floor lookup.
`default_nettype none
package drfl_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int HEAD_W  = 64;
    localparam int TAIL_W  = 16;
    localparam int KEY_W   = HEAD_W + TAIL_W;
    localparam int RATE_W  = 40;
    localparam int AMT_W   = 32;
    localparam int LIMIT_W = 31;
    localparam int PROD_W  = 50;
    localparam int ENTRY_W = KEY_W + RATE_W;

    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = MUL_P_W + 4;
    localparam int SUM_W   = ACC_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd65536000;
    localparam logic [PROD_W-1:0]  PROD_MAX    = {PROD_W{1'b1}};

    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_AMOUNT_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_DATE   = 3'd1,
        STAT_NEG_AMOUNT = 3'd2,
        STAT_TOO_LARGE  = 3'd3,
        STAT_FULL       = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                     cmd;
        logic [HEAD_W-1:0]        date_head;
        logic [TAIL_W-1:0]        date_tail;
        logic signed [AMT_W-1:0]  amount;
        logic [RATE_W-1:0]        rate_in;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic                found;
        logic [RATE_W-1:0]   rate_used;
        logic [PROD_W-1:0]   product;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RATE_W-1:0] rate;
    } entry_t;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PROBE,
        ST_CMP,
        ST_RESOLVE,
        ST_SRD,
        ST_SWR,
        ST_INS,
        ST_QRATE,
        ST_MUL_H,
        ST_MUL_L,
        ST_MUL_SUM,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== sv/dated_rate_floor_lookup.sv =====
// Top level: sorted rate table with insert and floor lookup, APB register.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_data  (drfl_pkg::in_item_t)
//  m_        out        m_valid / m_ready      m_data  (drfl_pkg::out_item_t)
//  apb       in/out     psel, penable, pready  paddr, pwdata, prdata
//
// A query runs a binary search, each probe a registered table read and then
// a key compare, then reads the rate and makes two passes through the shared
// multiplier. A new-key load moves each entry above the insert point up by
// one place, a read and then a write through the single memory port pair.
// Reset clears the entry count and sets the limit register to LIMIT_RESET;
// no memory sweep is needed. s_ready is high only while idle; a finished
// result waits in the output register.
`default_nettype none
module dated_rate_floor_lookup (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire drfl_pkg::in_item_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output drfl_pkg::out_item_t                m_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [drfl_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    drfl_pkg::state_t                    state_reg, state_next;
    drfl_pkg::in_item_t                  item_reg, item_next;
    logic [drfl_pkg::CNT_W-1:0]          lo_reg, lo_next;
    logic [drfl_pkg::CNT_W-1:0]          hi_reg, hi_next;
    logic [drfl_pkg::CNT_W-1:0]          mid_reg, mid_next;
    logic [drfl_pkg::CNT_W-1:0]          cur_reg, cur_next;
    logic [drfl_pkg::CNT_W-1:0]          count_reg, count_next;
    logic                                eq_reg, eq_next;
    drfl_pkg::status_t                   status_reg, status_next;
    logic                                found_reg, found_next;
    logic [drfl_pkg::RATE_W-1:0]         rate_reg, rate_next;
    logic [drfl_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [drfl_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [drfl_pkg::LIMIT_W-1:0]        limit_reg, limit_next;
    drfl_pkg::out_item_t                 out_reg, out_next;
    logic                                m_valid_reg, m_valid_next;

    logic                                date_ok;
    logic                                cfg_we;
    logic [drfl_pkg::KEY_W-1:0]          key;
    logic                                ram_we;
    logic [drfl_pkg::IDX_W-1:0]          ram_waddr;
    drfl_pkg::entry_t                    ram_wdata;
    logic [drfl_pkg::IDX_W-1:0]          ram_raddr;
    drfl_pkg::entry_t                    ram_rdata;
    drfl_pkg::mul_req_t                  mul_req;
    logic [drfl_pkg::MUL_P_W-1:0]        mul_p;
    logic [drfl_pkg::CNT_W-1:0]          probe_mid;
    logic [drfl_pkg::SUM_W-1:0]          sum;
    logic                                out_free;

    assign key      = {item_reg.date_head, item_reg.date_tail};
    assign s_ready  = (state_reg == drfl_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite
                      && (paddr[drfl_pkg::ADDR_W-1:2] == drfl_pkg::REG_AMOUNT_LIMIT);
    assign prdata   = (paddr[drfl_pkg::ADDR_W-1:2] == drfl_pkg::REG_AMOUNT_LIMIT)
                      ? {1'b0, limit_reg} : 32'd0;
    assign out_free = !m_valid_reg || m_ready;
    assign probe_mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sum = drfl_pkg::SUM_W'(acc_reg) + drfl_pkg::SUM_W'(mul_p >> 16);

    drfl_date_chk u_date_chk (
        .date_head (item_reg.date_head),
        .date_tail (item_reg.date_tail),
        .date_ok   (date_ok)
    );

    drfl_table_ram #(
        .DEPTH (drfl_pkg::TABLE_DEPTH),
        .WIDTH (drfl_pkg::ENTRY_W)
    ) u_table_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    drfl_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .p    (mul_p)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            drfl_pkg::ST_IDLE: begin
                if (s_valid) state_next = drfl_pkg::ST_CHECK;
            end
            drfl_pkg::ST_CHECK: begin
                if (item_reg.cmd == drfl_pkg::CMD_LOAD) begin
                    state_next = drfl_pkg::ST_PROBE;
                end else if (!date_ok || item_reg.amount[drfl_pkg::AMT_W-1]
                             || (item_reg.amount[drfl_pkg::LIMIT_W-1:0] > limit_reg)) begin
                    state_next = drfl_pkg::ST_DONE;
                end else begin
                    state_next = drfl_pkg::ST_PROBE;
                end
            end
            drfl_pkg::ST_PROBE: begin
                state_next = (lo_reg < hi_reg) ? drfl_pkg::ST_CMP : drfl_pkg::ST_RESOLVE;
            end
            drfl_pkg::ST_CMP: state_next = drfl_pkg::ST_PROBE;
            drfl_pkg::ST_RESOLVE: begin
                if (item_reg.cmd == drfl_pkg::CMD_LOAD) begin
                    if (eq_reg || count_reg >= drfl_pkg::CNT_W'(drfl_pkg::TABLE_DEPTH)) begin
                        state_next = drfl_pkg::ST_DONE;
                    end else begin
                        state_next = drfl_pkg::ST_SRD;
                    end
                end else begin
                    state_next = (lo_reg == '0) ? drfl_pkg::ST_DONE : drfl_pkg::ST_QRATE;
                end
            end
            drfl_pkg::ST_SRD: begin
                state_next = (cur_reg > lo_reg) ? drfl_pkg::ST_SWR : drfl_pkg::ST_INS;
            end
            drfl_pkg::ST_SWR:     state_next = drfl_pkg::ST_SRD;
            drfl_pkg::ST_INS:     state_next = drfl_pkg::ST_DONE;
            drfl_pkg::ST_QRATE:   state_next = drfl_pkg::ST_MUL_H;
            drfl_pkg::ST_MUL_H:   state_next = drfl_pkg::ST_MUL_L;
            drfl_pkg::ST_MUL_L:   state_next = drfl_pkg::ST_MUL_SUM;
            drfl_pkg::ST_MUL_SUM: state_next = drfl_pkg::ST_DONE;
            drfl_pkg::ST_DONE: begin
                if (out_free) state_next = drfl_pkg::ST_IDLE;
            end
            default: state_next = drfl_pkg::ST_IDLE;
        endcase
    end

    // memory and multiplier controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {key, item_reg.rate_in};
        ram_raddr = '0;
        mul_req.a = item_reg.amount[drfl_pkg::MUL_A_W-1:0];
        mul_req.b = rate_reg[drfl_pkg::RATE_W-1:drfl_pkg::MUL_B_W];
        case (state_reg)
            drfl_pkg::ST_PROBE: begin
                ram_raddr = probe_mid[drfl_pkg::IDX_W-1:0];
            end
            drfl_pkg::ST_RESOLVE: begin
                ram_raddr = drfl_pkg::IDX_W'(lo_reg - 1'b1);
                // key already present: overwrite its rate in place
                if (item_reg.cmd == drfl_pkg::CMD_LOAD && eq_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = drfl_pkg::IDX_W'(lo_reg - 1'b1);
                end
            end
            drfl_pkg::ST_SRD: begin
                ram_raddr = drfl_pkg::IDX_W'(cur_reg - 1'b1);
            end
            drfl_pkg::ST_SWR: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg[drfl_pkg::IDX_W-1:0];
                ram_wdata = ram_rdata;
            end
            drfl_pkg::ST_INS: begin
                ram_we    = 1'b1;
                ram_waddr = lo_reg[drfl_pkg::IDX_W-1:0];
            end
            drfl_pkg::ST_MUL_L: begin
                mul_req.b = rate_reg[drfl_pkg::MUL_B_W-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        item_next    = item_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        eq_next      = eq_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        rate_next    = rate_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        limit_next   = cfg_we ? pwdata[drfl_pkg::LIMIT_W-1:0] : limit_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            drfl_pkg::ST_IDLE: begin
                if (s_valid) item_next = s_data;
            end
            drfl_pkg::ST_CHECK: begin
                lo_next    = '0;
                hi_next    = count_reg;
                eq_next    = 1'b0;
                found_next = 1'b0;
                rate_next  = '0;
                prod_next  = '0;
                if (item_reg.cmd == drfl_pkg::CMD_LOAD) begin
                    status_next = drfl_pkg::STAT_OK;
                end else if (!date_ok) begin
                    status_next = drfl_pkg::STAT_BAD_DATE;
                end else if (item_reg.amount[drfl_pkg::AMT_W-1]) begin
                    status_next = drfl_pkg::STAT_NEG_AMOUNT;
                end else if (item_reg.amount[drfl_pkg::LIMIT_W-1:0] > limit_reg) begin
                    status_next = drfl_pkg::STAT_TOO_LARGE;
                end else begin
                    status_next = drfl_pkg::STAT_OK;
                end
            end
            drfl_pkg::ST_PROBE: begin
                mid_next = probe_mid;
            end
            drfl_pkg::ST_CMP: begin
                if (key >= ram_rdata.key) begin
                    lo_next = mid_reg + 1'b1;
                    if (key == ram_rdata.key) eq_next = 1'b1;
                end else begin
                    hi_next = mid_reg;
                end
            end
            drfl_pkg::ST_RESOLVE: begin
                cur_next = count_reg;
                if (item_reg.cmd == drfl_pkg::CMD_LOAD && !eq_reg
                    && count_reg >= drfl_pkg::CNT_W'(drfl_pkg::TABLE_DEPTH)) begin
                    status_next = drfl_pkg::STAT_FULL;
                end
            end
            drfl_pkg::ST_SWR: begin
                cur_next = cur_reg - 1'b1;
            end
            drfl_pkg::ST_INS: begin
                count_next = count_reg + 1'b1;
            end
            drfl_pkg::ST_QRATE: begin
                found_next = 1'b1;
                rate_next  = ram_rdata.rate;
            end
            drfl_pkg::ST_MUL_L: begin
                acc_next = {mul_p, 4'b0000};
            end
            drfl_pkg::ST_MUL_SUM: begin
                // clamp to the field width
                if (sum > drfl_pkg::SUM_W'(drfl_pkg::PROD_MAX)) begin
                    prod_next = drfl_pkg::PROD_MAX;
                end else begin
                    prod_next = sum[drfl_pkg::PROD_W-1:0];
                end
            end
            drfl_pkg::ST_DONE: begin
                if (out_free) begin
                    out_next.status    = status_reg;
                    out_next.found     = found_reg;
                    out_next.rate_used = rate_reg;
                    out_next.product   = prod_reg;
                    m_valid_next       = 1'b1;
                end
            end
            default: begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= drfl_pkg::ST_IDLE;
            count_reg   <= '0;
            limit_reg   <= drfl_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        cur_reg    <= cur_next;
        eq_reg     <= eq_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rate_reg   <= rate_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        out_reg    <= out_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= drfl_pkg::CNT_W'(drfl_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_only_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != drfl_pkg::ST_INS) |=> $stable(count_reg))
        else $error("entry count moved outside insert");

    a_found_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found) |-> (m_data.status == drfl_pkg::STAT_OK))
        else $error("found flag with error status");

    a_no_rate_without_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> (m_data.rate_used == '0 && m_data.product == '0))
        else $error("rate or product without a found entry");
`endif

endmodule
`default_nettype wire

// ===== sv/drfl_date_chk.sv =====
// Calendar check of a ten-character YYYY-MM-DD date.
`default_nettype none
module drfl_date_chk (
    input  wire logic [drfl_pkg::HEAD_W-1:0] date_head,
    input  wire logic [drfl_pkg::TAIL_W-1:0] date_tail,
    output logic                             date_ok
);

    logic [7:0] c [10];
    logic       digits_ok;
    logic [6:0] month;
    logic [6:0] day;
    logic [4:0] yy_mix;
    logic [4:0] cc_mix;
    logic       leap;
    logic [4:0] max_day;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            c[i] = date_head[drfl_pkg::HEAD_W-1-8*i -: 8];
        end
        c[8] = date_tail[15:8];
        c[9] = date_tail[7:0];
    end

    always_comb begin
        digits_ok = (c[4] == 8'h2D) && (c[7] == 8'h2D);
        for (int i = 0; i < 10; i++) begin
            if (i != 4 && i != 7) begin
                digits_ok = digits_ok && (c[i] >= 8'h30) && (c[i] <= 8'h39);
            end
        end
    end

    assign month = 7'(c[5][3:0]) * 7'd10 + 7'(c[6][3:0]);
    assign day   = 7'(c[8][3:0]) * 7'd10 + 7'(c[9][3:0]);

    // 10*a + b is divisible by 4 exactly when 2*a + b is
    assign yy_mix = {c[2][3:0], 1'b0} + 5'(c[3][3:0]);
    assign cc_mix = {c[0][3:0], 1'b0} + 5'(c[1][3:0]);

    always_comb begin
        if (c[2][3:0] == 4'd0 && c[3][3:0] == 4'd0) begin
            leap = (cc_mix[1:0] == 2'd0);
        end else begin
            leap = (yy_mix[1:0] == 2'd0);
        end
    end

    always_comb begin
        case (month)
            7'd4, 7'd6, 7'd9, 7'd11: max_day = 5'd30;
            7'd2:                    max_day = leap ? 5'd29 : 5'd28;
            default:                 max_day = 5'd31;
        endcase
    end

    assign date_ok = digits_ok && (month >= 7'd1) && (month <= 7'd12)
                     && (day >= 7'd1) && (day <= 7'(max_day));

endmodule
`default_nettype wire

// ===== sv/drfl_mul.sv =====
// Shared registered 31 x 20 multiplier used for both rate halves.
`default_nettype none
module drfl_mul (
    input  wire logic                        aclk,
    input  wire drfl_pkg::mul_req_t          req,
    output logic [drfl_pkg::MUL_P_W-1:0]     p
);

    logic [drfl_pkg::MUL_P_W-1:0] p_reg;
    logic [drfl_pkg::MUL_P_W-1:0] p_next;

    assign p_next = drfl_pkg::MUL_P_W'(req.a) * drfl_pkg::MUL_P_W'(req.b);

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== sv/drfl_table_ram.sv =====
// Single-write, single-read table memory with registered read data.
`default_nettype none
module drfl_table_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 120
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== tb/drfl_checker.sv =====
// Checker for the dated rate floor lookup: predicts every result and compares.
`timescale 1ns / 100ps
`default_nettype none
module drfl_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire drfl_pkg::in_item_t          s_data,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire drfl_pkg::out_item_t         m_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [drfl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    input  wire logic                        pready,
    output int unsigned                      fail_count,
    output int unsigned                      pending
);

    logic [drfl_pkg::KEY_W-1:0]   rate_keys  [drfl_pkg::TABLE_DEPTH];
    logic [drfl_pkg::RATE_W-1:0]  rate_vals  [drfl_pkg::TABLE_DEPTH];
    int unsigned                  rate_count;
    logic [drfl_pkg::LIMIT_W-1:0] limit_q;
    drfl_pkg::out_item_t          results_due[$];

    // number of stored keys not above k
    function automatic int unsigned keys_not_above(logic [drfl_pkg::KEY_W-1:0] k);
        int unsigned lo, hi, mid;
        lo = 0;
        hi = rate_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (k >= rate_keys[mid]) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic bit is_calendar_date(logic [drfl_pkg::HEAD_W-1:0] h,
                                            logic [drfl_pkg::TAIL_W-1:0] t);
        logic [7:0]  c [10];
        int unsigned yr, mo, dy, dmax;
        bit          leap;
        for (int i = 0; i < 8; i++) c[i] = h[63-8*i -: 8];
        c[8] = t[15:8];
        c[9] = t[7:0];
        if (c[4] != 8'h2D || c[7] != 8'h2D) return 1'b0;
        for (int i = 0; i < 10; i++)
            if (i != 4 && i != 7 && (c[i] < 8'h30 || c[i] > 8'h39)) return 1'b0;
        yr = (c[0]-8'h30)*1000 + (c[1]-8'h30)*100 + (c[2]-8'h30)*10 + (c[3]-8'h30);
        mo = (c[5]-8'h30)*10 + (c[6]-8'h30);
        dy = (c[8]-8'h30)*10 + (c[9]-8'h30);
        if (mo < 1 || mo > 12) return 1'b0;
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11) dmax = 30;
        else if (mo == 2) begin
            leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            dmax = leap ? 29 : 28;
        end else dmax = 31;
        return dy >= 1 && dy <= dmax;
    endfunction

    function automatic drfl_pkg::out_item_t predict_lookup(drfl_pkg::in_item_t it);
        drfl_pkg::out_item_t        r;
        logic [drfl_pkg::KEY_W-1:0] k;
        int unsigned                pos;
        logic [63:0]                a, p;
        r = '0;
        r.status = drfl_pkg::STAT_OK;
        k = {it.date_head, it.date_tail};
        pos = keys_not_above(k);
        if (it.cmd == drfl_pkg::CMD_LOAD) begin
            if (pos > 0 && rate_keys[pos-1] == k) rate_vals[pos-1] = it.rate_in;
            else if (rate_count >= drfl_pkg::TABLE_DEPTH) r.status = drfl_pkg::STAT_FULL;
            else begin
                for (int i = rate_count; i > pos; i--) begin
                    rate_keys[i] = rate_keys[i-1];
                    rate_vals[i] = rate_vals[i-1];
                end
                rate_keys[pos] = k;
                rate_vals[pos] = it.rate_in;
                rate_count++;
            end
        end else begin
            a = {32'd0, it.amount};
            if (!is_calendar_date(it.date_head, it.date_tail))
                r.status = drfl_pkg::STAT_BAD_DATE;
            else if (it.amount[drfl_pkg::AMT_W-1]) r.status = drfl_pkg::STAT_NEG_AMOUNT;
            else if (a > {33'd0, limit_q}) r.status = drfl_pkg::STAT_TOO_LARGE;
            else if (pos > 0) begin
                r.found = 1'b1;
                r.rate_used = rate_vals[pos-1];
                p = ((a * {44'd0, r.rate_used[39:20]}) << 4)
                    + ((a * {44'd0, r.rate_used[19:0]}) >> 16);
                r.product = (p > {14'd0, drfl_pkg::PROD_MAX}) ? drfl_pkg::PROD_MAX
                                                             : p[drfl_pkg::PROD_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        drfl_pkg::out_item_t want;
        if (!aresetn) begin
            rate_count = 0;
            limit_q = drfl_pkg::LIMIT_RESET;
            results_due.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == drfl_pkg::ADDR_W'(0))
                limit_q = pwdata[drfl_pkg::LIMIT_W-1:0];
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result %p", $realtime, m_data);
                end else begin
                    want = results_due.pop_front();
                    if (m_data.status !== want.status || m_data.found !== want.found ||
                        m_data.rate_used !== want.rate_used ||
                        m_data.product !== want.product) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, m_data);
                    end
                end
            end
            // predict after the compare so a same-edge result cannot see it
            if (s_valid && s_ready) results_due.push_back(predict_lookup(s_data));
            pending = results_due.size();
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb_dated_rate_floor_lookup.sv =====
// Testbench top: stimulus, register writes and verdict for the rate lookup.
`timescale 1ns / 100ps
`default_nettype none
module tb_dated_rate_floor_lookup;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    drfl_pkg::in_item_t            s_data = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    drfl_pkg::out_item_t           m_data;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [drfl_pkg::ADDR_W-1:0]   paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    int unsigned                   fail_count, pending;

    bit                            quiet = 1'b0;
    int unsigned                   ready_gap = 0;
    logic [drfl_pkg::LIMIT_W-1:0]  cur_limit = drfl_pkg::LIMIT_RESET;
    int unsigned                   n_loads = 0, n_queries = 0, n_limits = 0;

    dated_rate_floor_lookup dut (.*);

    drfl_checker u_checker (.*);

    initial forever #2 aclk = ~aclk;

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (ready_gap != 0) begin
            ready_gap <= ready_gap - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            ready_gap <= $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [drfl_pkg::KEY_W-1:0] date_key(int unsigned y, int unsigned m,
                                                            int unsigned d);
        return {8'h30 + 8'(y / 1000 % 10), 8'h30 + 8'(y / 100 % 10),
                8'h30 + 8'(y / 10 % 10), 8'h30 + 8'(y % 10), 8'h2D,
                8'h30 + 8'(m / 10 % 10), 8'h30 + 8'(m % 10), 8'h2D,
                8'h30 + 8'(d / 10 % 10), 8'h30 + 8'(d % 10)};
    endfunction

    function automatic logic [drfl_pkg::KEY_W-1:0] pick_key();
        logic [drfl_pkg::KEY_W-1:0] k;
        int unsigned                y, m, d;
        if ($urandom_range(0, 9) < 2) begin
            // raw bits; keep the top byte below the fill keys
            k = {$urandom, $urandom, 16'($urandom)};
            if (k[79:72] == 8'hFF) k[79:72] = 8'hFE;
            return k;
        end
        case ($urandom_range(0, 7))
            0: y = 0;
            1: y = 1900;
            2: y = 2000;
            3: y = 2024;
            4: y = 9999;
            5: y = $urandom_range(0, 9999);
            default: y = 2023;
        endcase
        m = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 19) : $urandom_range(1, 12);
        d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32) : $urandom_range(1, 28);
        return date_key(y, m, d);
    endfunction

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h8000_0000 | $urandom;
            2: return 32'(cur_limit);
            3: return 32'(cur_limit) + 1;
            4: return 32'd0;
            default: return $urandom_range(0, cur_limit);
        endcase
    endfunction

    task automatic send_item(logic [0:0] cmd, logic [drfl_pkg::KEY_W-1:0] k,
                             logic [31:0] amt, logic [drfl_pkg::RATE_W-1:0] rate);
        drfl_pkg::in_item_t it;
        it.cmd = cmd;
        it.date_head = k[79:16];
        it.date_tail = k[15:0];
        it.amount = amt;
        it.rate_in = rate;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == drfl_pkg::CMD_LOAD) n_loads++;
        else n_queries++;
    endtask

    task automatic load(logic [drfl_pkg::KEY_W-1:0] k, logic [drfl_pkg::RATE_W-1:0] rate);
        send_item(drfl_pkg::CMD_LOAD, k, $urandom, rate);
    endtask

    task automatic query(logic [drfl_pkg::KEY_W-1:0] k, logic [31:0] amt);
        send_item(drfl_pkg::CMD_QUERY, k, amt, {$urandom, 8'($urandom)});
    endtask

    // wait out every expected result, then let the bench idle before going on
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_limit(logic [drfl_pkg::LIMIT_W-1:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= drfl_pkg::ADDR_W'(drfl_pkg::REG_AMOUNT_LIMIT) << 2;
        pwdata <= {1'b0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_limit = v;
        n_limits++;
    endtask

    task automatic random_run(int unsigned n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0)
                load(pick_key(), {$urandom, 8'($urandom)});
            else
                query(pick_key(), pick_amount());
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, then insert, overwrite and floor edges
        query(date_key(2023, 6, 15), 32'h0001_0000);
        load(date_key(2023, 6, 15), 40'h00_0002_0000);
        load(date_key(2023, 1, 1), 40'hFF_FFFF_FFFF);
        load(date_key(2023, 6, 15), 40'h00_0003_8000);
        query(date_key(2022, 12, 31), 32'h0001_0000);
        query(date_key(2023, 1, 1), 32'(drfl_pkg::LIMIT_RESET));
        query(date_key(2023, 6, 14), 32'(drfl_pkg::LIMIT_RESET) + 1);
        query(date_key(2023, 6, 15), 32'h8000_0000);
        query(date_key(9999, 12, 31), 32'h7FFF_FFFF);
        load({8'h41, 72'h0}, 40'h0);
        query({date_key(2023, 6, 15)} ^ {32'h0, 8'h01, 40'h0}, 32'd5);
        query({date_key(2023, 6, 15)} ^ {72'h0, 8'h1F}, 32'd5);
        query(date_key(2023, 0, 10), 32'd5);
        query(date_key(2023, 13, 10), 32'd5);
        query(date_key(2023, 3, 0), 32'd5);
        query(date_key(2023, 4, 31), 32'd5);
        query(date_key(2024, 2, 29), 32'd5);
        query(date_key(2023, 2, 29), 32'd5);
        query(date_key(1900, 2, 29), 32'd5);
        query(date_key(2000, 2, 29), 32'd5);
        query(date_key(0, 2, 29), 32'd5);
        query(date_key(2023, 1, 32), 32'd5);
        drain();

        random_run(150);
        drain();
        set_limit('1);
        random_run(120);
        drain();
        set_limit('0);
        random_run(60);
        drain();
        set_limit(drfl_pkg::LIMIT_W'($urandom));
        random_run(170);
        drain();
        set_limit(drfl_pkg::LIMIT_RESET);

        // fill the table with appended keys, no idling from here on
        quiet = 1'b1;
        for (int i = 0; i < drfl_pkg::TABLE_DEPTH; i++)
            load({64'hFFFF_FFFF_FFFF_FFFF, 16'(i)}, {$urandom, 8'($urandom)});
        load({64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF}, 40'h1);
        load({64'hFFFF_FFFF_FFFF_FFFF, 16'h0000}, 40'h5);
        load(date_key(2023, 6, 16), 40'h7);
        load(date_key(2023, 6, 15), 40'h0_0009_0000);
        for (int i = 0; i < 20; i++) query(pick_key(), pick_amount());
        drain();

        $display("Covered %0d loads and %0d queries over %0d limit settings,",
                 n_loads, n_queries, n_limits + 1);
        $display("with random stalls on both channels and a full table at the end.");
        if (fail_count == 0 && pending == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
sv/drfl_pkg.sv
sv/drfl_date_chk.sv
sv/drfl_mul.sv
sv/drfl_table_ram.sv
sv/dated_rate_floor_lookup.sv
tb/drfl_checker.sv
tb/tb_dated_rate_floor_lookup.sv
